/* rtl/core/repeat_command_beacon_sequencer_unit_defines.svh */
// Assertion macros for the beacon sequencer.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef REPEAT_COMMAND_BEACON_SEQUENCER_UNIT_DEFINES_SVH
`define REPEAT_COMMAND_BEACON_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RCBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beacon sequencer check failed");

// Next-cycle implication.
`define RCBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beacon sequencer check failed");

`endif

/* rtl/core/rcbs_pkg.sv */
`default_nettype none
package rcbs_pkg;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_START       = 3'd1,
    OP_REQUEST     = 3'd2,
    OP_HEARTBEAT   = 3'd3,
    OP_NEW_SESSION = 3'd4,
    OP_MANUAL      = 3'd5,
    OP_AUTO        = 3'd6,
    OP_MOTION      = 3'd7
  } opcode_t;

  localparam logic [2:0] FC_HEARTBEAT  = 3'd0;
  localparam logic [2:0] FC_OPEN       = 3'd1;
  localparam logic [2:0] FC_WAKE       = 3'd4;
  localparam logic [2:0] FC_SET_PERIOD = 3'd5;

  localparam logic [2:0] REG_REPEAT_COUNT   = 3'd0;
  localparam logic [2:0] REG_FRAME_INTERVAL = 3'd1;
  localparam logic [2:0] REG_MOTION_HOLD    = 3'd2;
  localparam logic [2:0] REG_ACTIVE_PERIOD  = 3'd3;
  localparam logic [2:0] REG_IDLE_PERIOD    = 3'd4;

  localparam logic [7:0]  RST_REPEAT_COUNT   = 8'd3;
  localparam logic [15:0] RST_FRAME_INTERVAL = 16'd100;
  localparam logic [31:0] RST_MOTION_HOLD    = 32'd30000;
  localparam logic [15:0] RST_ACTIVE_PERIOD  = 16'd200;
  localparam logic [15:0] RST_IDLE_PERIOD    = 16'd1000;

  localparam logic [31:0] PERIOD_MAX = 32'h0000_FFFF;

  localparam int FRAME_BUF_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  repeat_count;
    logic [15:0] frame_interval;
    logic [31:0] motion_hold;
    logic [15:0] active_period;
    logic [15:0] idle_period;
  } cfg_t;

  typedef struct packed {
    logic        started;
    logic [7:0]  session_number;
    logic [15:0] sequence_counter;
    logic [2:0]  pending_command;
    logic [15:0] pending_argument;
    logic [15:0] pending_sequence;
    logic [7:0]  repeats_left;
    logic [15:0] frame_wait;
    logic        motion_active;
    logic        auto_mode;
    logic [31:0] ticks_since_motion;
    logic        previous_level;
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] seq_num;
    logic [15:0] argument;
    logic [7:0]  session;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [1:0] count;
    frame_t     first;
    frame_t     second;
  } step_out_t;

  typedef struct packed {
    logic avail;
    logic full;
  } buf_stat_t;

endpackage
`default_nettype wire

/* rtl/core/repeat_command_beacon_sequencer_unit.sv */
// Channel   Direction  Handshake              Word
// item      in         item_valid/item_stall  opcode, command_code, period_value, motion_level
// frame     out        frame_valid/frame_stall frame_command .. frame_session, last
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// When an item is taken, state updates at the accepting edge and its zero,
// one or two frame words enter the frame buffer in that same edge.
// The item side takes one item per cycle while the buffer has room for two words;
// the frame side drains one word per cycle while frame_stall is low, which sets the sustained rate.
// Synchronous reset loads defaults into state and config registers and empties the buffer.
// frame_stall holds the head word; item_stall rises when fewer than two slots are free.
`default_nettype none
`include "repeat_command_beacon_sequencer_unit_defines.svh"
module repeat_command_beacon_sequencer_unit #(
  parameter int FRAME_BUF_DEPTH = rcbs_pkg::FRAME_BUF_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  opcode,
  input  logic [2:0]  command_code,
  input  logic [31:0] period_value,
  input  logic        motion_level,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [2:0]  frame_command,
  output logic [15:0] frame_sequence,
  output logic [15:0] frame_argument,
  output logic [7:0]  frame_session,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rcbs_pkg::cfg_t      cfg;
  rcbs_pkg::state_t    st;
  rcbs_pkg::state_t    st_next;
  rcbs_pkg::step_out_t step;
  rcbs_pkg::step_out_t push;
  rcbs_pkg::frame_t    head;
  rcbs_pkg::buf_stat_t bstat;
  logic                item_accept;

  // Config writes are always taken; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_count   <= rcbs_pkg::RST_REPEAT_COUNT;
      cfg.frame_interval <= rcbs_pkg::RST_FRAME_INTERVAL;
      cfg.motion_hold    <= rcbs_pkg::RST_MOTION_HOLD;
      cfg.active_period  <= rcbs_pkg::RST_ACTIVE_PERIOD;
      cfg.idle_period    <= rcbs_pkg::RST_IDLE_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcbs_pkg::REG_REPEAT_COUNT:   cfg.repeat_count   <= cfg_data[7:0];
        rcbs_pkg::REG_FRAME_INTERVAL: cfg.frame_interval <= cfg_data[15:0];
        rcbs_pkg::REG_MOTION_HOLD:    cfg.motion_hold    <= cfg_data;
        rcbs_pkg::REG_ACTIVE_PERIOD:  cfg.active_period  <= cfg_data[15:0];
        rcbs_pkg::REG_IDLE_PERIOD:    cfg.idle_period    <= cfg_data[15:0];
        default:                      cfg                <= cfg;
      endcase
    end
  end

  // Whole item update in one pass of combinational logic.
  rcbs_step u_step (
    .st           (st),
    .cfg          (cfg),
    .opcode       (opcode),
    .command_code (command_code),
    .period_value (period_value),
    .motion_level (motion_level),
    .st_next      (st_next),
    .result       (step)
  );

  assign item_stall  = bstat.full;
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.started            <= 1'b0;
      st.session_number     <= 8'd1;
      st.sequence_counter   <= 16'd0;
      st.pending_command    <= rcbs_pkg::FC_HEARTBEAT;
      st.pending_argument   <= 16'd0;
      st.pending_sequence   <= 16'd0;
      st.repeats_left       <= 8'd0;
      st.frame_wait         <= 16'd0;
      st.motion_active      <= 1'b0;
      st.auto_mode          <= 1'b1;
      st.ticks_since_motion <= 32'd0;
      st.previous_level     <= 1'b1;
    end else if (item_accept) begin
      st <= st_next;
    end
  end

  // Push only words of an accepted item.
  always_comb begin
    push = step;
    if (!item_accept) begin
      push.count = 2'd0;
    end
  end

  rcbs_frame_buf #(
    .DEPTH (FRAME_BUF_DEPTH)
  ) u_frame_buf (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (frame_valid && !frame_stall),
    .head (head),
    .stat (bstat)
  );

  assign frame_valid    = bstat.avail;
  assign frame_command  = head.command;
  assign frame_sequence = head.seq_num;
  assign frame_argument = head.argument;
  assign frame_session  = head.session;
  assign last           = head.last;

  // Before start only the start opcode may emit a word.
  `RCBS_ASSERT_NOW(a_quiet_before_start,
    item_accept && !st.started && opcode != rcbs_pkg::OP_START, step.count == 2'd0)
  // A two-word item closes on its second word only.
  `RCBS_ASSERT_NOW(a_last_on_final,
    item_accept && step.count == 2'd2, step.second.last && !step.first.last)
  // Stall only while the buffer holds words to drain.
  `RCBS_ASSERT_NOW(a_stall_has_words, item_stall, frame_valid)
  // New session restarts the sequence at one.
  `RCBS_ASSERT_NEXT(a_session_restart,
    item_accept && opcode == rcbs_pkg::OP_NEW_SESSION, st.sequence_counter == 16'd1)

endmodule
`default_nettype wire

/* rtl/core/rcbs_step.sv */
`default_nettype none
module rcbs_step (
  input  rcbs_pkg::state_t    st,
  input  rcbs_pkg::cfg_t      cfg,
  input  logic [2:0]          opcode,
  input  logic [2:0]          command_code,
  input  logic [31:0]         period_value,
  input  logic                motion_level,
  output rcbs_pkg::state_t    st_next,
  output rcbs_pkg::step_out_t result
);

  // Load a command for repeating; drop it before start.
  function automatic rcbs_pkg::state_t queue_cmd(rcbs_pkg::state_t s, logic [7:0] reps,
                                                 logic [2:0] cmd, logic [15:0] arg);
    rcbs_pkg::state_t r;
    r = s;
    if (s.started) begin
      r.pending_command  = cmd;
      r.pending_argument = arg;
      r.repeats_left     = reps;
      r.sequence_counter = s.sequence_counter + 16'd1;
      r.pending_sequence = s.sequence_counter + 16'd1;
    end
    return r;
  endfunction

  rcbs_pkg::state_t  s;
  rcbs_pkg::frame_t  f0;
  rcbs_pkg::frame_t  f1;
  logic [1:0]        n;
  logic [15:0]       wait_dec;

  always_comb begin
    s        = st;
    n        = 2'd0;
    f0       = '0;
    f1       = '0;
    wait_dec = (st.frame_wait != 16'd0) ? st.frame_wait - 16'd1 : 16'd0;
    case (rcbs_pkg::opcode_t'(opcode))
      rcbs_pkg::OP_TICK: begin
        s.frame_wait = wait_dec;
        if (st.repeats_left != 8'd0 && wait_dec == 16'd0) begin
          s.frame_wait   = cfg.frame_interval;
          f0             = '{st.pending_command, st.pending_sequence,
                             st.pending_argument, st.session_number, 1'b0};
          n              = 2'd1;
          s.repeats_left = st.repeats_left - 8'd1;
          if (st.repeats_left == 8'd1) begin
            s.pending_command  = rcbs_pkg::FC_HEARTBEAT;
            s.pending_argument = 16'd0;
            s.sequence_counter = st.sequence_counter + 16'd1;
            f1 = '{rcbs_pkg::FC_HEARTBEAT, st.sequence_counter + 16'd1, 16'd0,
                   st.session_number, 1'b0};
            n  = 2'd2;
          end
        end
        if (st.ticks_since_motion != '1) begin
          s.ticks_since_motion = st.ticks_since_motion + 32'd1;
        end
        // Falling edge of the active-low pin counts as motion.
        if (!motion_level && st.previous_level) begin
          s.ticks_since_motion = 32'd0;
          if (st.auto_mode && !st.motion_active) begin
            s.motion_active = 1'b1;
            if (cfg.active_period != 16'd0) begin
              s = queue_cmd(s, cfg.repeat_count, rcbs_pkg::FC_SET_PERIOD, cfg.active_period);
            end
          end
        end
        s.previous_level = motion_level;
        if (s.auto_mode && s.motion_active && s.ticks_since_motion > cfg.motion_hold) begin
          s.motion_active = 1'b0;
          if (cfg.idle_period != 16'd0) begin
            s = queue_cmd(s, cfg.repeat_count, rcbs_pkg::FC_SET_PERIOD, cfg.idle_period);
          end
        end
      end
      rcbs_pkg::OP_START: begin
        if (!st.started) begin
          s.sequence_counter = st.sequence_counter + 16'd1;
          s.started          = 1'b1;
          f0 = '{rcbs_pkg::FC_HEARTBEAT, st.sequence_counter + 16'd1, 16'd0,
                 st.session_number, 1'b0};
          n  = 2'd1;
        end
      end
      rcbs_pkg::OP_REQUEST: begin
        if (command_code >= rcbs_pkg::FC_OPEN && command_code <= rcbs_pkg::FC_WAKE) begin
          s = queue_cmd(st, cfg.repeat_count, command_code, 16'd0);
        end
      end
      rcbs_pkg::OP_HEARTBEAT: begin
        s.repeats_left     = 8'd0;
        s.pending_command  = rcbs_pkg::FC_HEARTBEAT;
        s.pending_argument = 16'd0;
        s.sequence_counter = st.sequence_counter + 16'd1;
        if (st.started) begin
          f0 = '{rcbs_pkg::FC_HEARTBEAT, st.sequence_counter + 16'd1, 16'd0,
                 st.session_number, 1'b0};
          n  = 2'd1;
        end
      end
      rcbs_pkg::OP_NEW_SESSION: begin
        s.session_number   = st.session_number + 8'd1;
        s.sequence_counter = 16'd1;
        s.repeats_left     = 8'd0;
        if (st.started) begin
          f0 = '{rcbs_pkg::FC_HEARTBEAT, 16'd1, 16'd0, st.session_number + 8'd1, 1'b0};
          n  = 2'd1;
        end
      end
      rcbs_pkg::OP_MANUAL: begin
        if (period_value != 32'd0 && period_value <= rcbs_pkg::PERIOD_MAX) begin
          s = queue_cmd(st, cfg.repeat_count, rcbs_pkg::FC_SET_PERIOD, period_value[15:0]);
          s.auto_mode = 1'b0;
        end
      end
      rcbs_pkg::OP_AUTO: begin
        s.auto_mode     = 1'b1;
        s.motion_active = 1'b0;
      end
      rcbs_pkg::OP_MOTION: begin
        s.auto_mode          = 1'b1;
        s.ticks_since_motion = 32'd0;
        if (!st.motion_active) begin
          s.motion_active = 1'b1;
          if (cfg.active_period != 16'd0) begin
            s = queue_cmd(s, cfg.repeat_count, rcbs_pkg::FC_SET_PERIOD, cfg.active_period);
          end
        end
      end
      default: begin
        s = st;
      end
    endcase
    // Mark the final word of this item.
    if (n == 2'd2) begin
      f1.last = 1'b1;
    end else if (n == 2'd1) begin
      f0.last = 1'b1;
    end
  end

  assign st_next = s;
  assign result  = '{n, f0, f1};

endmodule
`default_nettype wire

/* rtl/core/rcbs_frame_buf.sv */
`default_nettype none
module rcbs_frame_buf #(
  parameter int DEPTH = rcbs_pkg::FRAME_BUF_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rcbs_pkg::step_out_t push,
  input  logic                pop,
  output rcbs_pkg::frame_t    head,
  output rcbs_pkg::buf_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  rcbs_pkg::frame_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_1;
  logic [PW-1:0] wr_ptr_2;
  logic [PW-1:0] rd_ptr_next;

  assign wr_ptr_1    = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
  assign wr_ptr_2    = (wr_ptr_1 == LAST_SLOT) ? '0 : wr_ptr_1 + PW'(1);
  assign rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr_1;
        2'd2:    wr_ptr <= wr_ptr_2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.avail = (count != '0);
  // Hold off new items unless two free slots remain.
  assign stat.full  = (count > CW'(DEPTH - 2));

endmodule
`default_nettype wire
